@@ rtl/core/ps2mt_pkg.sv @@
package ps2mt_pkg;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_HEIGHT = 1'd1;

	localparam int DEF_WIDTH  = 1024;
	localparam int DEF_HEIGHT = 768;

	localparam int MAX_DIMENSION_DEF = 4096;
	localparam int COUNTER_BITS_DEF  = 32;

	localparam logic [7:0] ST_OUT_FULL = 8'h01;
	localparam logic [7:0] ST_AUX      = 8'h20;
	localparam logic [7:0] B0_SYNC     = 8'h08;
	localparam logic [7:0] B0_OVERFLOW = 8'hC0;

	localparam logic EVT_MOVE   = 1'b0;
	localparam logic EVT_BUTTON = 1'b1;

	localparam logic [1:0] BTN_NONE   = 2'd0;
	localparam logic [1:0] BTN_LEFT   = 2'd1;
	localparam logic [1:0] BTN_RIGHT  = 2'd2;
	localparam logic [1:0] BTN_MIDDLE = 2'd3;

	typedef enum logic [1:0] {
		POS_FIRST  = 2'd0,
		POS_SECOND = 2'd1,
		POS_LAST   = 2'd2
	} byte_pos_t;

	typedef struct packed {
		logic [2:0] buttons;
		logic [7:0] dx;
		logic [7:0] dy;
	} pkt_t;

	typedef struct packed {
		logic drop;
		logic pkt_valid;
		pkt_t pkt;
	} asm_link_t;

endpackage

@@ rtl/core/ps2mt_ifs.sv @@
interface ps2mt_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] status_byte;
	logic [7:0] data_byte;

	modport source (output valid, status_byte, data_byte, input ready);
	modport sink (input valid, status_byte, data_byte, output ready);
endinterface

interface ps2mt_evt_if;
	logic              valid;
	logic              ready;
	logic              event_kind;
	logic [11:0]       pointer_x;
	logic [11:0]       pointer_y;
	logic signed [7:0] move_dx;
	logic signed [8:0] move_dy;
	logic [1:0]        button_id;
	logic              button_down;
	logic [31:0]       good_packets;
	logic [31:0]       dropped_items;
	logic [31:0]       button_events;
	logic              last;

	modport source (output valid, event_kind, pointer_x, pointer_y, move_dx, move_dy,
		button_id, button_down, good_packets, dropped_items, button_events, last,
		input ready);
	modport sink (input valid, event_kind, pointer_x, pointer_y, move_dx, move_dy,
		button_id, button_down, good_packets, dropped_items, button_events, last,
		output ready);
endinterface

@@ rtl/core/ps2mt_cfg.sv @@
module ps2mt_cfg import ps2mt_pkg::*; #(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
	localparam int POS_W = $clog2(MAX_DIMENSION)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output logic [POS_W-1:0]     lim_x,
	output logic [POS_W-1:0]     lim_y
);

	localparam int BND_W = $clog2(MAX_DIMENSION + 1);
	localparam int CMP_W = (BND_W > CFG_W) ? BND_W : CFG_W;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [POS_W-1:0] lim_x_q;
	logic [POS_W-1:0] lim_y_q;

	// highest allowed cursor coordinate for a bound register
	function automatic logic [POS_W-1:0] limit_of(input logic [CFG_W-1:0] r, input int dflt);
		logic [CMP_W-1:0] v;
		v = (r == '0) ? CMP_W'(dflt) : CMP_W'(r);
		if (v > CMP_W'(MAX_DIMENSION)) begin
			v = CMP_W'(MAX_DIMENSION);
		end
		return POS_W'(v - 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(DEF_WIDTH);
			height_q <= CFG_W'(DEF_HEIGHT);
			lim_x_q  <= limit_of(CFG_W'(DEF_WIDTH), DEF_WIDTH);
			lim_y_q  <= limit_of(CFG_W'(DEF_HEIGHT), DEF_HEIGHT);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BOUNDS_WIDTH:  width_q  <= cfg_wdata;
					REG_BOUNDS_HEIGHT: height_q <= cfg_wdata;
					default: ;
				endcase
			end
			lim_x_q <= limit_of(width_q, DEF_WIDTH);
			lim_y_q <= limit_of(height_q, DEF_HEIGHT);
		end
	end

	assign lim_x = lim_x_q;
	assign lim_y = lim_y_q;

endmodule

@@ rtl/core/ps2mt_asm.sv @@
module ps2mt_asm import ps2mt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ps2mt_rx_if.sink    rx,
	input  logic        pkt_ready,
	output asm_link_t   link
);

	logic       valid_s1;
	logic [7:0] status_s1;
	logic [7:0] data_s1;
	byte_pos_t  pos_q;
	byte_pos_t  pos_next;
	logic [7:0] b0_q;
	logic [7:0] dx_q;
	logic       byte_ok;
	logic       pkt_end;
	logic       overflow;
	logic       advance;

	always_comb begin
		byte_ok  = ((status_s1 & (ST_OUT_FULL | ST_AUX)) == (ST_OUT_FULL | ST_AUX))
			&& (pos_q != POS_FIRST || (data_s1 & B0_SYNC) != 8'd0);
		pkt_end  = byte_ok && pos_q == POS_LAST;
		overflow = (b0_q & B0_OVERFLOW) != 8'd0;
		link.drop        = valid_s1 && (!byte_ok || (pkt_end && overflow));
		link.pkt_valid   = valid_s1 && pkt_end && !overflow;
		link.pkt.buttons = b0_q[2:0];
		link.pkt.dx      = dx_q;
		link.pkt.dy      = data_s1;
		advance = valid_s1 && (!link.pkt_valid || pkt_ready);
	end

	always_comb begin
		pos_next = pos_q;
		if (advance && byte_ok) begin
			case (pos_q)
				POS_FIRST:  pos_next = POS_SECOND;
				POS_SECOND: pos_next = POS_LAST;
				default:    pos_next = POS_FIRST;
			endcase
		end
	end

	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q    <= POS_FIRST;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			pos_q <= pos_next;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			status_s1 <= rx.status_byte;
			data_s1   <= rx.data_byte;
		end
		if (advance && byte_ok && pos_q == POS_FIRST) begin
			b0_q <= data_s1;
		end
		if (advance && byte_ok && pos_q == POS_SECOND) begin
			dx_q <= data_s1;
		end
	end

endmodule

@@ rtl/core/ps2mt_emit.sv @@
module ps2mt_emit import ps2mt_pkg::*; #(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
	parameter int COUNTER_BITS  = COUNTER_BITS_DEF,
	localparam int POS_W = $clog2(MAX_DIMENSION)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  asm_link_t        link,
	output logic             pkt_ready,
	input  logic [POS_W-1:0] lim_x,
	input  logic [POS_W-1:0] lim_y,
	ps2mt_evt_if.source      evt
);

	localparam int SUM_W = ((POS_W > 8) ? POS_W : 8) + 2;
	localparam int DEF_W_EFF = (DEF_WIDTH > MAX_DIMENSION) ? MAX_DIMENSION : DEF_WIDTH;
	localparam int DEF_H_EFF = (DEF_HEIGHT > MAX_DIMENSION) ? MAX_DIMENSION : DEF_HEIGHT;
	localparam int RST_X = (DEF_WIDTH / 2 > DEF_W_EFF - 1) ? DEF_W_EFF - 1 : DEF_WIDTH / 2;
	localparam int RST_Y = (DEF_HEIGHT / 2 > DEF_H_EFF - 1) ? DEF_H_EFF - 1 : DEF_HEIGHT / 2;

	logic [POS_W-1:0]        pos_x_q;
	logic [POS_W-1:0]        pos_y_q;
	logic [2:0]              held_q;
	logic [2:0]              pend_q;
	logic [COUNTER_BITS-1:0] good_cnt_q;
	logic [COUNTER_BITS-1:0] drop_cnt_q;
	logic [COUNTER_BITS-1:0] btn_cnt_q;
	logic                    valid_q;
	logic                    kind_q;
	logic [11:0]             cx_q;
	logic [11:0]             cy_q;
	logic signed [7:0]       dx_q;
	logic signed [8:0]       dy_q;
	logic [1:0]              id_q;
	logic                    down_q;
	logic [31:0]             good_q;
	logic [31:0]             drop_q;
	logic [31:0]             bev_q;
	logic                    last_q;

	logic [POS_W-1:0]        base_x;
	logic [POS_W-1:0]        base_y;
	logic signed [8:0]       dy_neg;
	logic signed [SUM_W-1:0] sum_x;
	logic signed [SUM_W-1:0] sum_y;
	logic [POS_W-1:0]        new_x;
	logic [POS_W-1:0]        new_y;
	logic [2:0]              changed;
	logic [2:0]              sel;
	logic [1:0]              sel_id;
	logic [COUNTER_BITS-1:0] good_inc;
	logic [COUNTER_BITS-1:0] drop_inc;
	logic [COUNTER_BITS-1:0] btn_inc;
	logic                    out_free;
	logic                    load_btn;
	logic                    load_pkt;

	function automatic logic [POS_W-1:0] clamp_pos(input logic signed [SUM_W-1:0] s,
		input logic [POS_W-1:0] lim);
		logic [POS_W-1:0] r;
		if (s < 0) begin
			r = '0;
		end else if (s > $signed(SUM_W'(lim))) begin
			r = lim;
		end else begin
			r = POS_W'(s);
		end
		return r;
	endfunction

	always_comb begin
		// cursor pulled inside the bounds after a bounds write
		base_x = (pos_x_q > lim_x) ? lim_x : pos_x_q;
		base_y = (pos_y_q > lim_y) ? lim_y : pos_y_q;
		dy_neg = 9'sd0 - $signed({link.pkt.dy[7], link.pkt.dy});
		sum_x  = $signed(SUM_W'(base_x)) + SUM_W'($signed(link.pkt.dx));
		sum_y  = $signed(SUM_W'(base_y)) + SUM_W'(dy_neg);
		new_x  = clamp_pos(sum_x, lim_x);
		new_y  = clamp_pos(sum_y, lim_y);
		changed = held_q ^ link.pkt.buttons;

		sel    = 3'b000;
		sel_id = BTN_NONE;
		if (pend_q[0]) begin
			sel    = 3'b001;
			sel_id = BTN_LEFT;
		end else if (pend_q[1]) begin
			sel    = 3'b010;
			sel_id = BTN_RIGHT;
		end else if (pend_q[2]) begin
			sel    = 3'b100;
			sel_id = BTN_MIDDLE;
		end

		good_inc = (good_cnt_q == '1) ? good_cnt_q : good_cnt_q + 1'b1;
		drop_inc = (drop_cnt_q == '1) ? drop_cnt_q : drop_cnt_q + 1'b1;
		btn_inc  = (btn_cnt_q == '1) ? btn_cnt_q : btn_cnt_q + 1'b1;

		out_free  = !valid_q || evt.ready;
		load_btn  = out_free && pend_q != 3'd0;
		pkt_ready = out_free && pend_q == 3'd0;
		load_pkt  = link.pkt_valid && pkt_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			pend_q     <= 3'd0;
			held_q     <= 3'd0;
			pos_x_q    <= POS_W'(RST_X);
			pos_y_q    <= POS_W'(RST_Y);
			good_cnt_q <= '0;
			drop_cnt_q <= '0;
			btn_cnt_q  <= '0;
		end else begin
			if (load_btn) begin
				valid_q   <= 1'b1;
				pend_q    <= pend_q & ~sel;
				btn_cnt_q <= btn_inc;
			end else if (load_pkt) begin
				valid_q    <= 1'b1;
				pend_q     <= changed;
				held_q     <= link.pkt.buttons;
				good_cnt_q <= good_inc;
			end else if (evt.ready) begin
				valid_q <= 1'b0;
			end
			pos_x_q <= load_pkt ? new_x : base_x;
			pos_y_q <= load_pkt ? new_y : base_y;
			if (link.drop) begin
				drop_cnt_q <= drop_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_btn) begin
			kind_q <= EVT_BUTTON;
			dx_q   <= '0;
			dy_q   <= '0;
			id_q   <= sel_id;
			down_q <= |(held_q & sel);
			bev_q  <= 32'(btn_inc);
			last_q <= (pend_q & ~sel) == 3'd0;
		end else if (load_pkt) begin
			kind_q <= EVT_MOVE;
			cx_q   <= 12'(new_x);
			cy_q   <= 12'(new_y);
			dx_q   <= $signed(link.pkt.dx);
			dy_q   <= dy_neg;
			id_q   <= BTN_NONE;
			down_q <= 1'b0;
			good_q <= 32'(good_inc);
			drop_q <= 32'(drop_cnt_q);
			bev_q  <= 32'(btn_cnt_q);
			last_q <= changed == 3'd0;
		end
	end

	assign evt.valid         = valid_q;
	assign evt.event_kind    = kind_q;
	assign evt.pointer_x     = cx_q;
	assign evt.pointer_y     = cy_q;
	assign evt.move_dx       = dx_q;
	assign evt.move_dy       = dy_q;
	assign evt.button_id     = id_q;
	assign evt.button_down   = down_q;
	assign evt.good_packets  = good_q;
	assign evt.dropped_items = drop_q;
	assign evt.button_events = bev_q;
	assign evt.last          = last_q;

`ifndef SYNTH
	a_pend_shown: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 3'd0 |-> valid_q)
		else $error("button events pending without a result on the output");

	a_packet_continues: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.ready && !evt.last |=> evt.valid && evt.event_kind == EVT_BUTTON)
		else $error("packet ended without its last beat");

	a_button_fields: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.event_kind == EVT_BUTTON |->
			evt.move_dx == 8'sd0 && evt.move_dy == 9'sd0 && evt.button_id != BTN_NONE)
		else $error("button beat carries movement or no button");

	a_move_first: assert property (@(posedge clk) disable iff (!arst_n)
		load_pkt |=> evt.valid && evt.event_kind == EVT_MOVE && evt.button_id == BTN_NONE)
		else $error("packet did not start with a move beat");
`endif

endmodule

@@ rtl/core/ps2_mouse_packet_tracker.sv @@
// path: a byte completing a good packet is registered at the input, and its move beat is then
//   loaded into the single output register, followed by one button beat per changed button
// throughput: one byte per cycle, but a completing byte waits while that register is busy
// reset: arst_n clears position, buttons, counters and bounds to their defaults at once;
//   no clearing pass is needed
module ps2_mouse_packet_tracker import ps2mt_pkg::*; #(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
	parameter int COUNTER_BITS  = COUNTER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ps2mt_rx_if.sink             rx,
	ps2mt_evt_if.source          evt,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int POS_W = $clog2(MAX_DIMENSION);

	logic [POS_W-1:0] lim_x;
	logic [POS_W-1:0] lim_y;
	asm_link_t        link;
	logic             pkt_ready;

	ps2mt_cfg #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.lim_x    (lim_x),
		.lim_y    (lim_y)
	);

	ps2mt_asm u_asm (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.pkt_ready(pkt_ready),
		.link     (link)
	);

	ps2mt_emit #(
		.MAX_DIMENSION(MAX_DIMENSION),
		.COUNTER_BITS (COUNTER_BITS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.link     (link),
		.pkt_ready(pkt_ready),
		.lim_x    (lim_x),
		.lim_y    (lim_y),
		.evt      (evt)
	);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import ps2mt_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 55;
	localparam int PHASES = 8;
	localparam longint unsigned COUNT_TOP = 64'hFFFF_FFFF;
	localparam logic [7:0] ST_GOOD = ST_OUT_FULL | ST_AUX;
	localparam logic [1:0] BTN_ORDER [3] = '{BTN_LEFT, BTN_RIGHT, BTN_MIDDLE};
	localparam logic [CFG_W-1:0] W_SET [PHASES] = '{13'd0, 13'd4096, 13'd1, 13'd8191,
		13'd4095, 13'd640, 13'd0, 13'd1024};
	localparam logic [CFG_W-1:0] H_SET [PHASES] = '{13'd0, 13'd4096, 13'd1, 13'd8191,
		13'd2, 13'd480, 13'd0, 13'd768};

	typedef struct packed {
		logic        kind;
		logic [11:0] cx;
		logic [11:0] cy;
		logic [7:0]  dx;
		logic [8:0]  dy;
		logic [1:0]  id;
		logic        down;
		logic [31:0] good;
		logic [31:0] drops;
		logic [31:0] btns;
		logic        fin;
	} evt_beat_t;

	class mouse_event_board;
		evt_beat_t pending_events[$];
		int errors;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		logic [1:0] byte_pos;
		logic [7:0] held_bytes [2];
		int cur_x;
		int cur_y;
		logic [2:0] held_buttons;
		longint unsigned good_cnt;
		longint unsigned drop_cnt;
		longint unsigned button_cnt;

		function new();
			errors = 0;
			width_reg = CFG_W'(DEF_WIDTH);
			height_reg = CFG_W'(DEF_HEIGHT);
			byte_pos = 2'd0;
			held_bytes[0] = 8'h00;
			held_bytes[1] = 8'h00;
			cur_x = DEF_WIDTH / 2;
			cur_y = DEF_HEIGHT / 2;
			fit_cursor();
			held_buttons = 3'b000;
			good_cnt = 0;
			drop_cnt = 0;
			button_cnt = 0;
		endfunction

		function int bound(logic [CFG_W-1:0] r, int dflt);
			int v;
			v = (r == 0) ? dflt : int'(r);
			if (v > MAX_DIMENSION_DEF) v = MAX_DIMENSION_DEF;
			return v;
		endfunction

		function int clip(int v, int lim);
			if (v < 0) return 0;
			if (v >= lim) return lim - 1;
			return v;
		endfunction

		function longint unsigned bump(longint unsigned c);
			return (c >= COUNT_TOP) ? c : c + 1;
		endfunction

		function void fit_cursor();
			int w;
			int h;
			w = bound(width_reg, DEF_WIDTH);
			h = bound(height_reg, DEF_HEIGHT);
			if (cur_x >= w) cur_x = w - 1;
			if (cur_y >= h) cur_y = h - 1;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			if (idx == REG_BOUNDS_WIDTH) width_reg = v;
			else height_reg = v;
			fit_cursor();
		endfunction

		function evt_beat_t make_beat(logic kind, int dx, int dy, logic [1:0] id, logic down,
			logic fin);
			evt_beat_t e;
			e.kind = kind;
			e.cx = cur_x[11:0];
			e.cy = cur_y[11:0];
			e.dx = dx[7:0];
			e.dy = dy[8:0];
			e.id = id;
			e.down = down;
			e.good = good_cnt[31:0];
			e.drops = drop_cnt[31:0];
			e.btns = button_cnt[31:0];
			e.fin = fin;
			return e;
		endfunction

		function void absorb_byte(logic [7:0] st, logic [7:0] d);
			logic [7:0] b0;
			logic [2:0] flips;
			int dx;
			int dy;
			if ((st & ST_GOOD) != ST_GOOD || (byte_pos == 0 && (d & B0_SYNC) == 0)) begin
				drop_cnt = bump(drop_cnt);
				return;
			end
			if (byte_pos < 2) begin
				held_bytes[byte_pos[0]] = d;
				byte_pos++;
				return;
			end
			byte_pos = 0;
			b0 = held_bytes[0];
			if ((b0 & B0_SYNC) == 0 || (b0 & B0_OVERFLOW) != 0) begin
				drop_cnt = bump(drop_cnt);
				return;
			end
			dx = int'($signed(held_bytes[1]));
			dy = -int'($signed(d));
			cur_x = clip(cur_x + dx, bound(width_reg, DEF_WIDTH));
			cur_y = clip(cur_y + dy, bound(height_reg, DEF_HEIGHT));
			good_cnt = bump(good_cnt);
			flips = held_buttons ^ b0[2:0];
			pending_events.push_back(make_beat(EVT_MOVE, dx, dy, BTN_NONE, 1'b0, flips == 0));
			for (int i = 0; i < 3; i++) begin
				if (flips[i]) begin
					held_buttons[i] = b0[i];
					button_cnt = bump(button_cnt);
					pending_events.push_back(make_beat(EVT_BUTTON, 0, 0, BTN_ORDER[i], b0[i],
						(flips >> (i + 1)) == 0));
				end
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50) $display("%0t error: %s", $time, msg);
		endtask

		task cmp(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
		endtask

		task check_beat(evt_beat_t got);
			evt_beat_t want;
			if (pending_events.size() == 0) begin
				report("output beat with nothing pending");
				return;
			end
			want = pending_events.pop_front();
			cmp("event_kind", got.kind, want.kind);
			cmp("pointer_x", got.cx, want.cx);
			cmp("pointer_y", got.cy, want.cy);
			cmp("move_dx", got.dx, want.dx);
			cmp("move_dy", got.dy, want.dy);
			cmp("button_id", got.id, want.id);
			cmp("button_down", got.down, want.down);
			cmp("good_packets", got.good, want.good);
			cmp("dropped_items", got.drops, want.drops);
			cmp("button_events", got.btns, want.btns);
			cmp("last", got.fin, want.fin);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	bit hold_pending = 1'b0;
	int burst_left = 0;
	int sent = 0;
	int quiet_cycles = 0;
	evt_beat_t seen_beat;
	mouse_event_board sb;

	ps2mt_rx_if rx();
	ps2mt_evt_if evt();

	ps2_mouse_packet_tracker uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.evt(evt),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	assign seen_beat = {evt.event_kind, evt.pointer_x, evt.pointer_y, evt.move_dx, evt.move_dy,
		evt.button_id, evt.button_down, evt.good_packets, evt.dropped_items, evt.button_events,
		evt.last};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && rx.valid && rx.ready) sb.absorb_byte(rx.status_byte, rx.data_byte);
	end

	always @(posedge clk) begin
		if (arst_n && evt.valid && evt.ready) sb.check_beat(seen_beat);
	end

	always @(posedge clk) begin
		if (!arst_n || (rx.valid && rx.ready) || (evt.valid && evt.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t error: no beat moved for %0d cycles", $time, quiet_cycles);
			$display("ps2_mouse_packet_tracker: mismatch");
			$finish;
		end
	end

	initial begin : receiver
		int mode;
		int len;
		evt.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++) begin
					evt.ready <= 1'b0;
					@(posedge clk);
				end
			end else begin
				mode = $urandom_range(0, 4);
				len = $urandom_range(1, 40);
				for (int k = 0; k < len && !hold_pending; k++) begin
					case (mode)
						0, 1: evt.ready <= 1'b1;
						2: evt.ready <= 1'($urandom_range(0, 1));
						3: evt.ready <= ($urandom_range(0, 3) == 0);
						default: evt.ready <= 1'b0;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	function logic [7:0] good_status();
		return 8'($urandom) | ST_GOOD;
	endfunction

	function logic [7:0] bad_status();
		logic [7:0] s;
		do s = 8'($urandom); while ((s & ST_GOOD) == ST_GOOD);
		return s;
	endfunction

	task send_beat(input logic [7:0] st, input logic [7:0] d);
		rx.valid <= 1'b1;
		rx.status_byte <= st;
		rx.data_byte <= d;
		do @(posedge clk); while (!rx.ready);
		sent++;
	endtask

	task offer(input logic [7:0] st, input logic [7:0] d);
		if (burst_left == 0) begin
			rx.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24);
		end
		burst_left--;
		send_beat(st, d);
	endtask

	task packet(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
		offer(good_status(), b0);
		offer(good_status(), b1);
		offer(good_status(), b2);
	endtask

	task settle_out();
		rx.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task apply_bounds(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		if ($urandom_range(0, 1)) begin
			write_reg(REG_BOUNDS_WIDTH, w);
			write_reg(REG_BOUNDS_HEIGHT, h);
		end else begin
			write_reg(REG_BOUNDS_HEIGHT, h);
			write_reg(REG_BOUNDS_WIDTH, w);
		end
	endtask

	initial begin : stimulus
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [2:0] btn;
		int drift;
		sb = new();
		btn = 3'b000;
		arst_n <= 1'b0;
		rx.valid <= 1'b0;
		rx.status_byte <= 8'h00;
		rx.data_byte <= 8'h00;
		cfg_we <= 1'b0;
		cfg_index <= REG_BOUNDS_WIDTH;
		cfg_wdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults straight out of reset
		packet(8'h08, 8'h00, 8'h00);
		packet(8'h0F, 8'h7F, 8'h80);
		packet(8'h08, 8'h80, 8'h7F);
		packet(8'hC8, 8'h01, 8'h01);
		send_beat(ST_OUT_FULL, 8'h08);
		send_beat(ST_AUX, 8'h08);
		send_beat(8'h00, 8'hFF);
		send_beat(8'hFF, 8'h00);
		// bad status beat in the middle of a packet
		send_beat(8'hFF, 8'h3A);
		send_beat(8'hDE, 8'hFF);
		send_beat(8'hFF, 8'hFF);
		send_beat(ST_GOOD, 8'h01);
		packet(8'h4C, 8'h10, 8'h10);
		packet(8'h8F, 8'hF0, 8'h0F);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle_out();
			w = W_SET[ph];
			h = H_SET[ph];
			if (ph == 6) begin
				w = CFG_W'($urandom_range(0, 8191));
				h = CFG_W'($urandom_range(0, 8191));
			end
			apply_bounds(w, h);
			drift = $urandom_range(0, 2);
			if (ph == 1) begin
				hold_pending = 1'b1;
				burst_left = PHASE_ITEMS + 10;
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) != 0) begin
					if ($urandom_range(0, 1)) btn = 3'($urandom);
					b0 = {($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'b00,
						2'($urandom), 1'b1, btn};
					b1 = 8'($urandom);
					b2 = 8'($urandom);
					if (drift == 1) begin
						b1[7] = 1'b0;
						b2[7] = 1'b1;
					end else if (drift == 2) begin
						b1[7] = 1'b1;
						b2[7] = 1'b0;
					end
					packet(b0, b1, b2);
				end else begin
					case ($urandom_range(0, 3))
						0: offer(bad_status(), 8'($urandom));
						1: offer(good_status(), 8'($urandom));
						2: begin
							offer(good_status(), 8'($urandom) | B0_SYNC);
							offer(good_status(), 8'($urandom));
						end
						default: offer(good_status(), 8'($urandom) & ~B0_SYNC);
					endcase
				end
			end
		end

		settle_out();
		if (sb.errors == 0) $display("ps2_mouse_packet_tracker: match");
		else $display("ps2_mouse_packet_tracker: mismatch");
		$finish;
	end

endmodule

@@ ps2_mouse_packet_tracker.f @@
rtl/core/ps2mt_pkg.sv
rtl/core/ps2mt_ifs.sv
rtl/core/ps2mt_cfg.sv
rtl/core/ps2mt_asm.sv
rtl/core/ps2mt_emit.sv
rtl/core/ps2_mouse_packet_tracker.sv
tb/tb_top.sv
